>>> src/rwl_pkg.sv
`default_nettype none

package rwl_pkg;

  // Table geometry and field widths.
  localparam int ZONE_SLOTS  = 64;
  localparam int ZONE_W      = 6;
  localparam int THREAD_W    = 8;
  localparam int READER_W    = 8;
  localparam int COUNT_W     = 32;
  localparam int AVG_W       = 16;
  localparam int TIME_W      = 16;
  localparam int VER_W       = 32;
  localparam int LIMIT_W     = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [READER_W-1:0] READER_MAX = {READER_W{1'b1}};

  // Divide by ten as a multiply by a rounded-up reciprocal of 2^23 / 10.
  // The sum 9*avg + t fits in 20 bits, well inside the exact range of 2^22.
  localparam int                   AVG_SUM_W   = 20;
  localparam int                   DIV10_SHIFT = 23;
  localparam int                   PROD_W      = 2 * AVG_SUM_W;
  localparam logic [AVG_SUM_W-1:0] DIV10_MUL   = 20'd838861;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_ACQUIRE = 3'd2,
    OP_RELEASE = 3'd3,
    OP_RECORD  = 3'd4,
    OP_BUMP    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_SHARED = 2'd1,
    ST_EXCL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_READ     = 2'd0,
    MODE_WRITE    = 2'd1,
    MODE_EXCL     = 2'd2,
    MODE_MATERIAL = 2'd3
  } mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENABLE = 1'd0,
    CFG_LIMIT  = 1'd1
  } cfg_reg_e;

  // One entry of the slot memory.
  typedef struct packed {
    status_e              status;
    logic                 owner_valid;
    logic [THREAD_W-1:0]  owner;
    logic [READER_W-1:0]  readers;
    logic [COUNT_W-1:0]   access_cnt;
    logic [COUNT_W-1:0]   conflict_cnt;
    logic [AVG_W-1:0]     average;
    logic                 contention;
    logic [VER_W-1:0]     version;
  } slot_entry_t;

  // One captured operation.
  typedef struct packed {
    logic [2:0]          op;
    logic [ZONE_W-1:0]   zone;
    logic [THREAD_W-1:0] thread_id;
    logic [1:0]          access_mode;
    logic [TIME_W-1:0]   access_time;
    logic                had_conflict;
  } req_t;

  // One result item.
  typedef struct packed {
    logic                ok;
    logic [1:0]          lock_status;
    logic                owner_valid;
    logic [THREAD_W-1:0] owner_thread;
    logic [READER_W-1:0] readers;
    logic                high_contention;
    logic [VER_W-1:0]    version;
    logic [AVG_W-1:0]    average_time;
  } rsp_t;

  // Write-back controls from the update logic to the table.
  typedef struct packed {
    logic entry_we;
    logic valid_we;
    logic valid_val;
  } upd_ctrl_t;

endpackage

`default_nettype wire

>>> src/rwl_req_if.sv
`default_nettype none

interface rwl_req_if
  import rwl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic [ZONE_W-1:0]   zone;
  logic [THREAD_W-1:0] thread_id;
  logic [1:0]          access_mode;
  logic [TIME_W-1:0]   access_time;
  logic                had_conflict;

  modport source (
    output valid, op, zone, thread_id, access_mode, access_time, had_conflict,
    input  ready
  );
  modport sink (
    input  valid, op, zone, thread_id, access_mode, access_time, had_conflict,
    output ready
  );
endinterface

`default_nettype wire

>>> src/rwl_rsp_if.sv
`default_nettype none

interface rwl_rsp_if
  import rwl_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                ok;
  logic [1:0]          lock_status;
  logic                owner_valid;
  logic [THREAD_W-1:0] owner_thread;
  logic [READER_W-1:0] readers;
  logic                high_contention;
  logic [VER_W-1:0]    version;
  logic [AVG_W-1:0]    average_time;

  modport source (
    output valid, ok, lock_status, owner_valid, owner_thread, readers,
           high_contention, version, average_time,
    input  ready
  );
  modport sink (
    input  valid, ok, lock_status, owner_valid, owner_thread, readers,
           high_contention, version, average_time,
    output ready
  );
endinterface

`default_nettype wire

>>> src/rwl_cfg_if.sv
`default_nettype none

interface rwl_cfg_if
  import rwl_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

>>> src/zone_reader_writer_lock_table.sv
// Flow: the slot is read at the transfer edge, then the update and write-back run
//   and the result is registered; the update waits while the output is stalled.
// Occupancy: one operation is in work at a time, set by the single read-modify-write
//   pass through the slot memory.
// Reset: all slots empty, block disabled, conflict limit 10; no clearing pass.
`default_nettype none

module zone_reader_writer_lock_table
  import rwl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rwl_req_if.sink   in_i,
  rwl_rsp_if.source out_o,
  rwl_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EXEC = 2'b10
  } fsm_e;

  fsm_e                 state_q, state_d;
  req_t                 req_q;
  logic [ZONE_SLOTS-1:0] valid_q;
  logic [ZONE_SLOTS-1:0] valid_d;
  logic                 enabled_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic                 out_valid_q;
  rsp_t                 out_data_q;

  logic        in_xfer;
  logic        cfg_we;
  logic        done;
  slot_entry_t rd_entry;
  slot_entry_t wr_entry;
  upd_ctrl_t   ctrl;
  rsp_t        rsp;
  logic        mem_we;

  assign in_i.ready  = (state_q == FSM_IDLE);
  assign in_xfer     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;
  assign done        = (state_q == FSM_EXEC) && (!out_valid_q || out_o.ready);
  assign mem_we      = done && ctrl.entry_we;

  // Slot storage.
  rwl_slot_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (req_q.zone),
    .wdata_i (wr_entry),
    .re_i    (in_xfer),
    .raddr_i (in_i.zone),
    .rdata_o (rd_entry)
  );

  // Lock and statistics update for the captured operation.
  rwl_update u_upd (
    .req_i        (req_q),
    .entry_i      (rd_entry),
    .slot_valid_i (valid_q[req_q.zone]),
    .enabled_i    (enabled_q),
    .limit_i      (limit_q),
    .entry_o      (wr_entry),
    .ctrl_o       (ctrl),
    .rsp_o        (rsp)
  );

  // Sequencer: capture, then update once the output register is free.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (in_xfer) state_d = FSM_EXEC;
      FSM_EXEC: if (done) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Captured operation fields.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q.op           <= in_i.op;
      req_q.zone         <= in_i.zone;
      req_q.thread_id    <= in_i.thread_id;
      req_q.access_mode  <= in_i.access_mode;
      req_q.access_time  <= in_i.access_time;
      req_q.had_conflict <= in_i.had_conflict;
    end
  end

  // Next slot valid bits; disabling the block empties every slot.
  always_comb begin
    valid_d = valid_q;
    if (done && ctrl.valid_we) begin
      valid_d[req_q.zone] = ctrl.valid_val;
    end
    if (cfg_we && (cfg_i.index == CFG_ENABLE) && enabled_q && !cfg_i.data[0]) begin
      valid_d = '0;
    end
  end

  // Configuration registers and slot valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      limit_q   <= LIMIT_W'(10);
      valid_q   <= '0;
    end else begin
      valid_q <= valid_d;
      if (cfg_we) begin
        unique case (cfg_reg_e'(cfg_i.index))
          CFG_ENABLE: enabled_q <= cfg_i.data[0];
          CFG_LIMIT:  limit_q <= cfg_i.data[LIMIT_W-1:0];
          default:    limit_q <= limit_q;
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= rsp;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.ok              = out_data_q.ok;
  assign out_o.lock_status     = out_data_q.lock_status;
  assign out_o.owner_valid     = out_data_q.owner_valid;
  assign out_o.owner_thread    = out_data_q.owner_thread;
  assign out_o.readers         = out_data_q.readers;
  assign out_o.high_contention = out_data_q.high_contention;
  assign out_o.version         = out_data_q.version;
  assign out_o.average_time    = out_data_q.average_time;

  // A stalled result keeps the sequencer from finishing the next operation.
  a_exec_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_EXEC) && out_valid_q && !out_o.ready |=> (state_q == FSM_EXEC))
    else $error("operation finished while output register was occupied");

  // The memory is written only by a finishing operation.
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == FSM_EXEC) && (!out_valid_q || out_o.ready))
    else $error("slot memory written outside an update");

  // Disabling the block empties every slot.
  a_disable_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && (cfg_i.index == CFG_ENABLE) && !cfg_i.data[0] |=> (valid_q == '0))
    else $error("slots remain valid after disable");

  // A disabled block never reports success.
  a_disabled_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !enabled_q |=> out_valid_q && !out_data_q.ok)
    else $error("operation succeeded while disabled");

endmodule

`default_nettype wire

>>> src/rwl_slot_mem.sv
`default_nettype none

module rwl_slot_mem
  import rwl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ZONE_W-1:0] waddr_i,
  input  wire slot_entry_t       wdata_i,
  input  wire logic              re_i,
  input  wire logic [ZONE_W-1:0] raddr_i,
  output slot_entry_t            rdata_o
);

  slot_entry_t mem_q [ZONE_SLOTS];
  slot_entry_t rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/rwl_update.sv
`default_nettype none

module rwl_update
  import rwl_pkg::*;
(
  input  wire req_t            req_i,
  input  wire slot_entry_t     entry_i,
  input  wire logic            slot_valid_i,
  input  wire logic            enabled_i,
  input  wire logic [LIMIT_W-1:0] limit_i,
  output slot_entry_t          entry_o,
  output upd_ctrl_t            ctrl_o,
  output rsp_t                 rsp_o
);

  logic                 ok;
  logic                 valid_after;
  slot_entry_t          nxt;
  logic                 shared_mode;
  logic [COUNT_W-1:0]   acc_new;
  logic [COUNT_W-1:0]   con_new;
  logic [AVG_SUM_W-1:0] avg_sum;
  logic [PROD_W-1:0]    avg_prod;
  logic [AVG_W-1:0]     avg_div;
  logic [COUNT_W+3:0]   con_x10;
  logic [READER_W-1:0]  readers_dec;

  assign shared_mode = (mode_e'(req_i.access_mode) inside {MODE_READ, MODE_MATERIAL});

  // Statistics of a recorded access: saturating counters and running average.
  always_comb begin
    acc_new = (entry_i.access_cnt == '1) ? entry_i.access_cnt
                                         : entry_i.access_cnt + COUNT_W'(1);
    con_new = entry_i.conflict_cnt;
    if (req_i.had_conflict && (entry_i.conflict_cnt != '1)) begin
      con_new = entry_i.conflict_cnt + COUNT_W'(1);
    end
    avg_sum  = AVG_SUM_W'({entry_i.average, 3'b000}) + AVG_SUM_W'(entry_i.average)
             + AVG_SUM_W'(req_i.access_time);
    avg_prod = PROD_W'(avg_sum) * PROD_W'(DIV10_MUL);
    avg_div  = avg_prod[DIV10_SHIFT +: AVG_W];
    con_x10  = (COUNT_W + 4)'({con_new, 3'b000}) + (COUNT_W + 4)'({con_new, 1'b0});
  end

  assign readers_dec = (entry_i.readers != '0) ? entry_i.readers - READER_W'(1)
                                               : entry_i.readers;

  // Operation decoder: new slot entry, success flag and valid-bit update.
  always_comb begin
    nxt         = entry_i;
    ok          = 1'b0;
    valid_after = slot_valid_i;
    if (enabled_i) begin
      unique case (op_e'(req_i.op))
        OP_CREATE: begin
          if (!slot_valid_i) begin
            nxt         = '0;
            nxt.status  = ST_FREE;
            ok          = 1'b1;
            valid_after = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (slot_valid_i) begin
            ok          = 1'b1;
            valid_after = 1'b0;
          end
        end
        OP_ACQUIRE: begin
          if (slot_valid_i) begin
            if (shared_mode) begin
              if ((entry_i.status != ST_EXCL) && (entry_i.readers != READER_MAX)) begin
                nxt.readers = entry_i.readers + READER_W'(1);
                nxt.status  = ST_SHARED;
                ok          = 1'b1;
              end
            end else if (entry_i.status == ST_FREE) begin
              nxt.owner       = req_i.thread_id;
              nxt.owner_valid = 1'b1;
              nxt.status      = ST_EXCL;
              ok              = 1'b1;
            end
          end
        end
        OP_RELEASE: begin
          if (slot_valid_i) begin
            if (entry_i.status == ST_EXCL) begin
              if (entry_i.owner_valid && (entry_i.owner == req_i.thread_id)) begin
                nxt.owner       = '0;
                nxt.owner_valid = 1'b0;
                nxt.status      = ST_FREE;
                ok              = 1'b1;
              end
            end else if (entry_i.status == ST_SHARED) begin
              nxt.readers = readers_dec;
              if (readers_dec == '0) begin
                nxt.status = ST_FREE;
              end
              ok = 1'b1;
            end
          end
        end
        OP_RECORD: begin
          if (slot_valid_i) begin
            nxt.access_cnt   = acc_new;
            nxt.conflict_cnt = con_new;
            nxt.average      = (acc_new <= COUNT_W'(1)) ? req_i.access_time : avg_div;
            nxt.contention   = (con_x10 > (COUNT_W + 4)'(acc_new))
                            || (con_new > COUNT_W'(limit_i));
            ok               = 1'b1;
          end
        end
        OP_BUMP: begin
          if (slot_valid_i) begin
            nxt.version = entry_i.version + VER_W'(1);
            ok          = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  assign entry_o         = nxt;
  assign ctrl_o.entry_we = ok;
  assign ctrl_o.valid_we = ok;
  assign ctrl_o.valid_val = valid_after;

  // Result fields show the slot after the operation, zero if it is empty.
  always_comb begin
    rsp_o    = '0;
    rsp_o.ok = ok;
    if (enabled_i && valid_after) begin
      rsp_o.lock_status     = nxt.status;
      rsp_o.owner_valid     = nxt.owner_valid;
      rsp_o.owner_thread    = nxt.owner_valid ? nxt.owner : '0;
      rsp_o.readers         = nxt.readers;
      rsp_o.high_contention = nxt.contention;
      rsp_o.version         = nxt.version;
      rsp_o.average_time    = nxt.average;
    end
  end

endmodule

`default_nettype wire
